FILE: rtl/idaa_pkg.sv
// Shared types and constants of the decimal ASCII conversion unit.
package idaa_pkg;

  localparam int unsigned MAX_CHARS = 21;
  localparam int unsigned ROOM_W    = 5;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SMALL = 1'b1;

  typedef struct packed {
    logic [63:0]        value;
    logic               is_signed;
    logic signed [15:0] buffer_size;
  } req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       char_valid;
    logic       last;
    logic       status;
  } rsp_t;

  // Commands from the sequencer to the BCD shifter; at most one is set.
  typedef struct packed {
    logic load;
    logic dabble;
    logic dshift;
  } bcd_cmd_t;

endpackage

FILE: rtl/integer_to_decimal_ascii_unit.sv
// Top level of the decimal ASCII conversion unit: sequencer and output register.
// Steps: bit-serial conversion of all shifter bits, then stripping of leading
// and excess digits, then one character per cycle while rsp_ready stays high.
// One word at a time: a new request is taken only back in idle.
// The one-bit-per-cycle double-dabble shifter sets the conversion time.
// Error and empty results leave in the cycle after acceptance.
// Reset (rst, synchronous) returns the sequencer to idle and empties the output.
module integer_to_decimal_ascii_unit import idaa_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // Shifter width covers unsigned values and the 32-bit signed magnitude.
  localparam int unsigned SW     = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam int unsigned NDIG   = (SW * 30103) / 100000 + 1;
  localparam int unsigned CONV_W = $clog2(SW + 1);
  localparam int unsigned ND_W   = $clog2(NDIG + 1);

  typedef enum logic [2:0] {
    IDLE,
    CONV,
    STRIP,
    SIGN,
    EMIT
  } state_t;

  state_t            state;
  logic [CONV_W-1:0] cnt;
  logic [ND_W-1:0]   nd;
  logic [ROOM_W-1:0] room;
  logic              neg;
  logic              cut;

  bcd_cmd_t          cmd;
  logic [SW-1:0]     load_value;
  logic [3:0]        top_digit;

  logic              accept;
  logic              out_free;
  logic              rsp_load;
  logic [31:0]       sw_word;
  logic [31:0]       sw_abs;
  logic [ROOM_W-1:0] nd_ext;
  logic              strip_more;

  idaa_bcd #(
    .SW   (SW),
    .NDIG (NDIG)
  ) u_bcd (
    .clk        (clk),
    .cmd        (cmd),
    .load_value (load_value),
    .top_digit  (top_digit)
  );

  // Output register is free when empty or being taken this cycle.
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == IDLE) && out_free;
  assign accept    = req_valid && req_ready;

  // A new word enters the output register this cycle.
  assign rsp_load = ((state == IDLE) && accept && (req.buffer_size <= 16'sd1)) ||
                    (((state == SIGN) || (state == EMIT)) && out_free);

  // Signed mode: take the magnitude of the low word; the most negative
  // value wraps to 2^31, which the unsigned shifter holds fine.
  assign sw_word = req.value[31:0];
  assign sw_abs  = sw_word[31] ? (~sw_word + 32'd1) : sw_word;

  always_comb begin
    if (req.is_signed) begin
      load_value = SW'(sw_abs);
    end else begin
      load_value = SW'(req.value[VALUE_WIDTH-1:0]);
    end
  end

  assign nd_ext = ROOM_W'(nd);
  // Drop leading zeros (keep one digit) and any digits beyond the room; once a
  // nonzero digit has been cut off, keep the zeros that follow it.
  assign strip_more = ((nd > ND_W'(1)) && (top_digit == 4'd0) && !cut) ||
                      (nd_ext > room);

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE:  cmd.load   = accept && (req.buffer_size > 16'sd1);
      CONV:  cmd.dabble = 1'b1;
      STRIP: cmd.dshift = strip_more;
      SIGN:  cmd        = '0;
      EMIT:  cmd.dshift = out_free;
      default: cmd      = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (req.buffer_size <= 16'sd0) begin
              rsp_valid <= 1'b1;
              rsp       <= '{character: 8'd0, char_valid: 1'b0, last: 1'b1,
                             status: STATUS_SMALL};
            end else if (req.buffer_size == 16'sd1) begin
              rsp_valid <= 1'b1;
              rsp       <= '{character: 8'd0, char_valid: 1'b0, last: 1'b1,
                             status: STATUS_OK};
            end else begin
              neg   <= req.is_signed && sw_word[31];
              cut   <= 1'b0;
              cnt   <= CONV_W'(SW);
              state <= CONV;
              if (req.buffer_size > $signed(16'(MAX_CHARS + 1))) begin
                room <= ROOM_W'(MAX_CHARS);
              end else begin
                room <= ROOM_W'(req.buffer_size - 16'sd1);
              end
            end
          end
        end
        CONV: begin
          cnt <= cnt - CONV_W'(1);
          if (cnt == CONV_W'(1)) begin
            nd    <= ND_W'(NDIG);
            state <= STRIP;
          end
        end
        STRIP: begin
          if (strip_more) begin
            nd <= nd - ND_W'(1);
            if (top_digit != 4'd0) begin
              cut <= 1'b1;
            end
          end else if (neg && (nd_ext < room)) begin
            state <= SIGN;
          end else begin
            state <= EMIT;
          end
        end
        SIGN: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp       <= '{character: CHAR_MINUS, char_valid: 1'b1, last: 1'b0,
                           status: STATUS_OK};
            state     <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp       <= '{character: CHAR_ZERO + {4'd0, top_digit}, char_valid: 1'b1,
                           last: (nd == ND_W'(1)), status: STATUS_OK};
            nd        <= nd - ND_W'(1);
            if (nd == ND_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // A size error is always a lone, empty, final word.
  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> rsp.last && !rsp.char_valid)
    else $error("size error word not a lone empty last word");

  // An empty word only ever ends a conversion.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.char_valid |-> rsp.last)
    else $error("empty word without last");

  // A conversion that starts keeps the input closed on the next cycle.
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !req_ready)
    else $error("input open while converting");

  // Digit count never runs out while characters remain.
  a_nd_live: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT) || (state == SIGN) |-> nd != '0)
    else $error("digit count empty during emission");

endmodule

FILE: rtl/idaa_bcd.sv
// Bit-serial double-dabble shifter with a digit-wide left shift for readout.
module idaa_bcd import idaa_pkg::*; #(
  parameter int unsigned SW   = 64,
  parameter int unsigned NDIG = 20
) (
  input  logic            clk,
  input  bcd_cmd_t        cmd,
  input  logic [SW-1:0]   load_value,
  output logic [3:0]      top_digit
);

  logic [SW-1:0]       bin;
  logic [NDIG*4-1:0]   bcd;
  logic [NDIG*4-1:0]   bcd_adj;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= load_value;
      bcd <= '0;
    end else if (cmd.dabble) begin
      bin <= {bin[SW-2:0], 1'b0};
      bcd <= {bcd_adj[NDIG*4-2:0], bin[SW-1]};
    end else if (cmd.dshift) begin
      bcd <= {bcd[NDIG*4-5:0], 4'd0};
    end
  end

  assign top_digit = bcd[NDIG*4-1 -: 4];

endmodule
